// ===== rtl/core/catmull_rom_sample_interpolator_unit_macros.svh =====
// Assertion macros shared by the interpolator RTL.
`ifndef CATMULL_ROM_SAMPLE_INTERPOLATOR_UNIT_MACROS_SVH
`define CATMULL_ROM_SAMPLE_INTERPOLATOR_UNIT_MACROS_SVH

`ifndef SYNTH
`define CRSI_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CRSI_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CRSI_AST_IMP(lbl, ante, cons)
`define CRSI_AST_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/crsi_pkg.sv =====
// Package: widths, codes and shared types of the Catmull-Rom interpolator.
package crsi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SAMP_W    = 16;
    localparam int IDX_W     = 10;
    localparam int POS_W     = 26;
    localparam int OUT_W     = 40;
    localparam int CNT_W     = 11;
    localparam int CNT_RST   = 1024;
    localparam int MIN_COUNT = 3;
    localparam int DEPTH_DEF = 1024;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    localparam int WIN_W  = SAMP_W + 2;
    localparam int COEF_W = WIN_W + 4;
    localparam int U_W    = POS_W;
    localparam int UX_W   = U_W + 1;
    localparam int CK     = 28;
    localparam int P_W    = COEF_W + UX_W;
    localparam int H1_R   = ((P_W > COEF_W + FRAC_BITS) ? P_W : COEF_W + FRAC_BITS) + 1;
    localparam int H1_N   = (H1_R + CK - 1) / CK;
    localparam int H1_W   = H1_N * CK;
    localparam int H2_N   = (H1_W + UX_W + 1 + CK - 1) / CK;
    localparam int H2_W   = H2_N * CK;
    localparam int H3_W   = H2_W + UX_W + 1;
    localparam int PR_W   = CK + 1 + UX_W;
    localparam int RND_SH = 2 * FRAC_BITS + 1;

    typedef struct packed {
        logic signed [COEF_W-1:0] a3;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a0;
        logic        [U_W-1:0]    u;
    } t_coef;

endpackage

// ===== rtl/core/crsi_ifs.sv =====
// Request and result channel interfaces.
interface crsi_req_if import crsi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic        [IDX_W-1:0]  sample_index;
    logic signed [SAMP_W-1:0] sample_value;
    logic        [POS_W-1:0]  position;

    modport source (output valid, req_type, sample_index, sample_value, position,
                    input ready);
    modport sink   (input valid, req_type, sample_index, sample_value, position,
                    output ready);
endinterface

interface crsi_rsp_if import crsi_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] interp_value;
    logic                    clipped;

    modport source (output valid, interp_value, clipped, input ready);
    modport sink   (input valid, interp_value, clipped, output ready);
endinterface

// ===== rtl/core/catmull_rom_sample_interpolator_unit.sv =====
// Top level: Catmull-Rom sample interpolator with APB count register.
// Write requests store one sample into a four-bank store at the edge they are
// accepted; an evaluate request issued any later cycle sees it. An evaluate
// request passes nine register stages (bank read, window and coefficients, six
// arithmetic stages for the Horner cubic with split multiplies, rounding and
// saturation into the output register) before its result is presented. One
// request is taken per cycle unless the full pipeline stalls behind a waiting
// result; the four banks let all window samples be read in a single cycle, and
// bubbles collapse so requests keep entering while a result waits.
// Register 0 (byte 0) is sample_count, clamped to 3..STORE_DEPTH in use; write
// it only while no request is in flight.
module catmull_rom_sample_interpolator_unit import crsi_pkg::*; #(
    parameter int STORE_DEPTH = DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    crsi_req_if.sink    i_req,
    crsi_rsp_if.source  o_rsp
);
    localparam logic REG_SAMPLE_COUNT = 1'b0;
    localparam int   EFF_RST = (CNT_RST > STORE_DEPTH) ? STORE_DEPTH : CNT_RST;

    logic [CNT_W-1:0] r_cnt, r_cnt_eff, n_cnt_eff, wv;
    logic             wr, f_valid, p_ready;
    t_coef            coef;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && paddr[2] == REG_SAMPLE_COUNT;
    assign wv     = pwdata[CNT_W-1:0];
    assign prdata = (paddr[2] == REG_SAMPLE_COUNT) ? 32'(r_cnt) : '0;

    always_comb begin
        if (wv < CNT_W'(MIN_COUNT)) begin
            n_cnt_eff = CNT_W'(MIN_COUNT);
        end else if (32'(wv) > 32'(STORE_DEPTH)) begin
            n_cnt_eff = CNT_W'(STORE_DEPTH);
        end else begin
            n_cnt_eff = wv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= CNT_W'(CNT_RST);
            r_cnt_eff <= CNT_W'(EFF_RST);
        end else if (wr) begin
            r_cnt     <= wv;
            r_cnt_eff <= n_cnt_eff;
        end
    end

    crsi_fetch #(.STORE_DEPTH(STORE_DEPTH)) u_fetch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cnt   (r_cnt_eff),
        .i_ready (p_ready),
        .o_valid (f_valid),
        .o_coef  (coef)
    );

    crsi_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (p_ready),
        .i_coef  (coef),
        .o_rsp   (o_rsp)
    );
endmodule

// ===== rtl/core/crsi_ram.sv =====
// Generic single-write, single-read RAM with registered read.
module crsi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/crsi_fetch.sv =====
// Request decode, four-bank sample store, window build and spline coefficients.
`include "catmull_rom_sample_interpolator_unit_macros.svh"
module crsi_fetch import crsi_pkg::*; #(
    parameter int STORE_DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    crsi_req_if.sink         i_req,
    input  logic [CNT_W-1:0] i_cnt,
    input  logic             i_ready,
    output logic             o_valid,
    output t_coef            o_coef
);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int BD = (STORE_DEPTH + 3) / 4;
    localparam int RW = (BD > 1) ? $clog2(BD) : 1;
    localparam int XW = POS_W - FRAC_BITS;
    localparam int BW = CNT_W + FRAC_BITS;

    typedef enum logic [1:0] {K_EXACT, K_START, K_END, K_MID} t_kind;

    logic en1, en2, acc;
    logic r_v1, r_v2;
    t_kind r_kind1, n_kind;
    logic [1:0] r_rot1;
    logic [U_W-1:0] r_u1, n_u;
    logic [XW-1:0] xi;
    logic [FRAC_BITS-1:0] fr;
    logic [BW-1:0] base, pos_w;
    logic [AW-1:0] b;
    logic [SAMP_W-1:0] rd [4];
    logic signed [SAMP_W-1:0] y [4];
    logic signed [WIN_W-1:0] w [4];
    logic signed [COEF_W-1:0] c [4];
    t_coef n_coef, r_coef;

    assign en2 = !r_v2 || i_ready;
    assign en1 = !r_v1 || en2;
    assign i_req.ready = en1;
    assign acc = i_req.valid && en1;

    always_comb begin
        xi    = i_req.position[POS_W-1:FRAC_BITS];
        fr    = i_req.position[FRAC_BITS-1:0];
        pos_w = BW'(i_req.position);
        base  = {i_cnt - CNT_W'(2), {FRAC_BITS{1'b0}}};
        if (fr == '0 && 32'(xi) < 32'(i_cnt)) begin
            n_kind = K_EXACT;
            b      = AW'(xi);
            n_u    = '0;
        end else if (xi == '0) begin
            n_kind = K_START;
            b      = '0;
            n_u    = U_W'(fr);
        end else if (pos_w > base) begin
            n_kind = K_END;
            b      = AW'(i_cnt - CNT_W'(MIN_COUNT));
            n_u    = U_W'(pos_w - base);
        end else begin
            n_kind = K_MID;
            b      = AW'(xi - XW'(1));
            n_u    = U_W'(fr);
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [1:0]    j;
        logic [AW:0]   a;
        logic [RW-1:0] row, wrow;
        logic          we;
        logic [31:0]   idx32;

        assign idx32 = 32'(i_req.sample_index);
        assign j     = 2'(k) - b[1:0];
        assign a     = (AW+1)'(b) + (AW+1)'(j);
        assign row   = RW'(a >> 2);
        assign wrow  = RW'(idx32 >> 2);
        assign we    = acc && i_req.req_type == REQ_WRITE
                       && idx32 < 32'(STORE_DEPTH) && i_req.sample_index[1:0] == 2'(k);

        crsi_ram #(.WIDTH(SAMP_W), .DEPTH(BD)) u_bank (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (wrow),
            .i_wdata (i_req.sample_value),
            .i_re    (en1),
            .i_raddr (row),
            .o_rdata (rd[k])
        );
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            y[j] = $signed(rd[r_rot1 + 2'(j)]);
            w[j] = WIN_W'(y[j]);
        end
        case (r_kind1)
            K_START: begin
                w[0] = (WIN_W'(y[0]) <<< 1) - WIN_W'(y[1]);
                w[1] = WIN_W'(y[0]);
                w[2] = WIN_W'(y[1]);
                w[3] = WIN_W'(y[2]);
            end
            K_END: begin
                w[3] = (WIN_W'(y[2]) <<< 1) - WIN_W'(y[1]);
            end
            default: begin
            end
        endcase
        for (int j = 0; j < 4; j++) begin
            c[j] = COEF_W'(w[j]);
        end
        n_coef.a3 = c[3] - (c[2] + (c[2] <<< 1)) + (c[1] + (c[1] <<< 1)) - c[0];
        n_coef.a2 = (c[2] <<< 2) - c[3] - ((c[1] <<< 2) + c[1]) + (c[0] <<< 1);
        n_coef.a1 = c[2] - c[0];
        n_coef.a0 = c[1] <<< 1;
        n_coef.u  = r_u1;
        if (r_kind1 == K_EXACT) begin
            n_coef.a3 = '0;
            n_coef.a2 = '0;
            n_coef.a1 = '0;
            n_coef.a0 = c[0] <<< 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= acc && i_req.req_type == REQ_EVAL;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_kind1 <= n_kind;
            r_rot1  <= b[1:0];
            r_u1    <= n_u;
        end
        if (en2) begin
            r_coef <= n_coef;
        end
    end

    assign o_valid = r_v2;
    assign o_coef  = r_coef;

    `CRSI_AST_NXT(a_eval_enters, acc && i_req.req_type == REQ_EVAL, r_v1)
    `CRSI_AST_NXT(a_write_no_entry, acc && i_req.req_type == REQ_WRITE, !r_v1)
endmodule

// ===== rtl/core/crsi_poly.sv =====
// Pipelined cubic evaluation, rounding and saturation.
`include "catmull_rom_sample_interpolator_unit_macros.svh"
module crsi_poly import crsi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_coef     i_coef,
    crsi_rsp_if.source o_rsp
);
    localparam logic signed [H3_W-1:0] MAX_V = {{(H3_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [H3_W-1:0] MIN_V = {{(H3_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] OUT_MAX_V = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN_V = {1'b1, {(OUT_W-1){1'b0}}};

    logic [6:1] r_v, en;
    logic en_o, r_vo;

    logic signed [P_W-1:0]    r_p;
    logic signed [H1_W-1:0]   r_h1;
    logic signed [PR_W-1:0]   r_pr1 [H1_N];
    logic signed [PR_W-1:0]   n_pr1 [H1_N];
    logic signed [H2_W-1:0]   r_h2, n_h2;
    logic signed [PR_W-1:0]   r_pr2 [H2_N];
    logic signed [PR_W-1:0]   n_pr2 [H2_N];
    logic signed [H3_W-1:0]   r_h3, n_h3, sh;
    logic signed [COEF_W-1:0] r_a2_1, r_a1_1, r_a1_2, r_a1_3, r_a0_1, r_a0_2, r_a0_3;
    logic signed [COEF_W-1:0] r_a0_4, r_a0_5;
    logic [U_W-1:0]           r_u_1, r_u_2, r_u_3, r_u_4;
    logic signed [CK:0]       ch1 [H1_N];
    logic signed [CK:0]       ch2 [H2_N];
    logic signed [OUT_W-1:0]  r_val, n_val;
    logic                     r_clip, n_clip;

    always_comb begin
        en_o  = !r_vo || o_rsp.ready;
        en[6] = !r_v[6] || en_o;
        for (int k = 5; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end
    assign o_ready = en[1];

    always_comb begin
        for (int j = 0; j < H1_N; j++) begin
            if (j == H1_N - 1) begin
                ch1[j] = (CK+1)'($signed(r_h1[j*CK +: CK]));
            end else begin
                ch1[j] = {1'b0, r_h1[j*CK +: CK]};
            end
            n_pr1[j] = ch1[j] * $signed({1'b0, r_u_2});
        end
        n_h2 = H2_W'(r_a1_3) <<< (2 * FRAC_BITS);
        for (int j = 0; j < H1_N; j++) begin
            n_h2 = n_h2 + (H2_W'(r_pr1[j]) <<< (j * CK));
        end
        for (int j = 0; j < H2_N; j++) begin
            if (j == H2_N - 1) begin
                ch2[j] = (CK+1)'($signed(r_h2[j*CK +: CK]));
            end else begin
                ch2[j] = {1'b0, r_h2[j*CK +: CK]};
            end
            n_pr2[j] = ch2[j] * $signed({1'b0, r_u_4});
        end
        n_h3 = (H3_W'(r_a0_5) <<< (3 * FRAC_BITS)) + (H3_W'(1) <<< (2 * FRAC_BITS));
        for (int j = 0; j < H2_N; j++) begin
            n_h3 = n_h3 + (H3_W'(r_pr2[j]) <<< (j * CK));
        end
        sh = r_h3 >>> RND_SH;
        if (sh > MAX_V) begin
            n_val  = OUT_MAX_V;
            n_clip = 1'b1;
        end else if (sh < MIN_V) begin
            n_val  = OUT_MIN_V;
            n_clip = 1'b1;
        end else begin
            n_val  = OUT_W'(sh);
            n_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vo <= 1'b0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (en_o) begin
                r_vo <= r_v[6];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_p    <= i_coef.a3 * $signed({1'b0, i_coef.u});
            r_a2_1 <= i_coef.a2;
            r_a1_1 <= i_coef.a1;
            r_a0_1 <= i_coef.a0;
            r_u_1  <= i_coef.u;
        end
        if (en[2]) begin
            r_h1   <= H1_W'(r_p) + (H1_W'(r_a2_1) <<< FRAC_BITS);
            r_a1_2 <= r_a1_1;
            r_a0_2 <= r_a0_1;
            r_u_2  <= r_u_1;
        end
        if (en[3]) begin
            r_pr1  <= n_pr1;
            r_a1_3 <= r_a1_2;
            r_a0_3 <= r_a0_2;
            r_u_3  <= r_u_2;
        end
        if (en[4]) begin
            r_h2   <= n_h2;
            r_a0_4 <= r_a0_3;
            r_u_4  <= r_u_3;
        end
        if (en[5]) begin
            r_pr2  <= n_pr2;
            r_a0_5 <= r_a0_4;
        end
        if (en[6]) begin
            r_h3 <= n_h3;
        end
        if (en_o) begin
            r_val  <= n_val;
            r_clip <= n_clip;
        end
    end

    assign o_rsp.valid        = r_vo;
    assign o_rsp.interp_value = r_val;
    assign o_rsp.clipped      = r_clip;

    `CRSI_AST_IMP(a_clip_bound, r_vo && r_clip, r_val == OUT_MAX_V || r_val == OUT_MIN_V)
    `CRSI_AST_NXT(a_last_hold, r_v[6] && !en[6], r_v[6])
    `CRSI_AST_IMP(a_ready_full, !o_ready, r_v[1] && r_v[6] && r_vo)
endmodule
